>>> sv/bam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block average mosaic package
// Frame geometry, derived widths and the request types shared by the modules.
// ----------------------------------------------------------------------------
package bam_pkg;

  localparam int IMAGE_SIZE  = 512;
  localparam int LEVELS      = 7;

  localparam int RAW_BLOCK   = IMAGE_SIZE >> (LEVELS - 1);
  localparam int BLOCK_SIZE  = (RAW_BLOCK > 0) ? RAW_BLOCK : 1;
  localparam int FULL_BLOCKS = IMAGE_SIZE / BLOCK_SIZE;
  localparam int SUM_SLOTS   = (IMAGE_SIZE + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int BLOCK_LOG2  = $clog2(BLOCK_SIZE + 1) - 1;
  localparam int MEAN_SHIFT  = 2 * BLOCK_LOG2;

  localparam int POS_W = $clog2(IMAGE_SIZE);
  localparam int IDX_W = $clog2(SUM_SLOTS);
  localparam int BLK_W = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
  localparam int SUM_W = $clog2(BLOCK_SIZE * BLOCK_SIZE * 255 + 1);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(IMAGE_SIZE - 1);
  localparam logic [BLK_W-1:0] BLK_LAST  = BLK_W'(BLOCK_SIZE - 1);
  localparam logic [IDX_W:0]   IDX_FULL  = (IDX_W + 1)'(FULL_BLOCKS);
  localparam logic [IDX_W-1:0] IDX_FINAL = IDX_W'(FULL_BLOCKS - 1);
  localparam logic [5:0]       COORD_FINAL = 6'(FULL_BLOCKS - 1);

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } bam_in_t;

  typedef struct packed {
    logic [7:0] block_mean;
    logic [5:0] block_row;
    logic [5:0] block_col;
    logic       frame_done;
  } bam_out_t;

  typedef struct packed {
    logic [7:0]       pixel;
    logic [IDX_W-1:0] slot;
    logic             reload;
    logic             emit;
    logic [5:0]       block_row;
    logic             frame_done;
  } bam_cmd_t;

endpackage

>>> sv/bam_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, read-first read data.
// ----------------------------------------------------------------------------
module bam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/bam_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block average mosaic front end
// Track the raster position and classify each pixel request for the back end.
// ----------------------------------------------------------------------------
module bam_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              pix_valid,
  output logic              pix_ready,
  input  bam_pkg::bam_in_t  pix_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output bam_pkg::bam_cmd_t cmd_data
);

  import bam_pkg::*;

  logic [POS_W-1:0] col, row;
  logic [BLK_W-1:0] in_col, in_row;
  logic [IDX_W-1:0] bcol, brow;

  logic [POS_W-1:0] cur_col, cur_row, col_next, row_next;
  logic [BLK_W-1:0] cur_in_col, cur_in_row, in_col_next, in_row_next;
  logic [IDX_W-1:0] cur_bcol, cur_brow, bcol_next, brow_next;
  logic             accept;

  assign pix_ready = cmd_ready;
  assign cmd_valid = pix_valid;
  assign accept    = pix_valid && pix_ready;

  always_comb begin
    cur_col    = pix_data.frame_start ? '0 : col;
    cur_row    = pix_data.frame_start ? '0 : row;
    cur_in_col = pix_data.frame_start ? '0 : in_col;
    cur_in_row = pix_data.frame_start ? '0 : in_row;
    cur_bcol   = pix_data.frame_start ? '0 : bcol;
    cur_brow   = pix_data.frame_start ? '0 : brow;

    cmd_data.pixel      = pix_data.pixel;
    cmd_data.slot       = cur_bcol;
    cmd_data.reload     = (cur_in_row == '0) && (cur_in_col == '0);
    cmd_data.emit       = (cur_in_row == BLK_LAST) && (cur_in_col == BLK_LAST) &&
                          ({1'b0, cur_bcol} < IDX_FULL) && ({1'b0, cur_brow} < IDX_FULL);
    cmd_data.block_row  = 6'(cur_brow);
    cmd_data.frame_done = (cur_brow == IDX_FINAL) && (cur_bcol == IDX_FINAL);

    col_next    = cur_col + POS_W'(1);
    in_col_next = cur_in_col + BLK_W'(1);
    bcol_next   = cur_bcol;
    row_next    = cur_row;
    in_row_next = cur_in_row;
    brow_next   = cur_brow;
    if (cur_in_col == BLK_LAST) begin
      in_col_next = '0;
      bcol_next   = cur_bcol + IDX_W'(1);
    end
    if (cur_col == POS_LAST) begin
      col_next    = '0;
      in_col_next = '0;
      bcol_next   = '0;
      row_next    = cur_row + POS_W'(1);
      in_row_next = cur_in_row + BLK_W'(1);
      if (cur_in_row == BLK_LAST) begin
        in_row_next = '0;
        brow_next   = cur_brow + IDX_W'(1);
      end
      if (cur_row == POS_LAST) begin
        row_next    = '0;
        in_row_next = '0;
        brow_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col    <= '0;
      row    <= '0;
      in_col <= '0;
      in_row <= '0;
      bcol   <= '0;
      brow   <= '0;
    end else if (accept) begin
      col    <= col_next;
      row    <= row_next;
      in_col <= in_col_next;
      in_row <= in_row_next;
      bcol   <= bcol_next;
      brow   <= brow_next;
    end
  end

endmodule

>>> sv/bam_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block average mosaic request queue
// Short FIFO between the classifying front end and the accumulating back end.
// ----------------------------------------------------------------------------
module bam_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push_valid,
  output logic                          push_ready,
  input  bam_pkg::bam_cmd_t             push_data,
  output logic                          pop_valid,
  input  logic                          pop_ready,
  output bam_pkg::bam_cmd_t             pop_data,
  output logic [bam_pkg::Q_CNT_W-1:0]   level
);

  import bam_pkg::*;

  bam_cmd_t           slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic               push, pop;

  assign push_ready = (level != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (level != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + Q_CNT_W'(1);
      end else if (pop && !push) begin
        level <= level - Q_CNT_W'(1);
      end
    end
  end

endmodule

>>> sv/bam_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block average mosaic back end
// Read-modify-write the block column sums and emit the mean of each block.
// ----------------------------------------------------------------------------
module bam_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  bam_pkg::bam_cmd_t cmd_data,
  output logic              blk_valid,
  input  logic              blk_ready,
  output bam_pkg::bam_out_t blk_data
);

  import bam_pkg::*;

  logic             b_valid;
  bam_cmd_t         b_cmd;
  logic             lw_valid;
  logic [IDX_W-1:0] lw_addr;
  logic [SUM_W-1:0] lw_data;

  logic [SUM_W-1:0] rd_data, old_sum, sum_next, shifted;
  logic             out_free, b_fire, pop;

  assign out_free  = !blk_valid || blk_ready;
  assign b_fire    = b_valid && (!b_cmd.emit || out_free);
  assign cmd_ready = !b_valid || b_fire;
  assign pop       = cmd_valid && cmd_ready;

  bam_ram #(
    .WIDTH (SUM_W),
    .DEPTH (SUM_SLOTS)
  ) u_sums (
    .clk     (clk),
    .wr_en   (b_fire),
    .wr_addr (b_cmd.slot),
    .wr_data (sum_next),
    .rd_en   (pop),
    .rd_addr (cmd_data.slot),
    .rd_data (rd_data)
  );

  always_comb begin
    old_sum  = (lw_valid && (lw_addr == b_cmd.slot)) ? lw_data : rd_data;
    sum_next = b_cmd.reload ? SUM_W'(b_cmd.pixel) : old_sum + SUM_W'(b_cmd.pixel);
    shifted  = sum_next >> MEAN_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_cmd <= cmd_data;
    end
    if (b_fire) begin
      lw_addr <= b_cmd.slot;
      lw_data <= sum_next;
    end
    if (b_fire && b_cmd.emit) begin
      blk_data.block_mean <= shifted[7:0];
      blk_data.block_row  <= b_cmd.block_row;
      blk_data.block_col  <= 6'(b_cmd.slot);
      blk_data.frame_done <= b_cmd.frame_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      lw_valid  <= 1'b0;
      blk_valid <= 1'b0;
    end else begin
      if (pop) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (b_fire) begin
        lw_valid <= 1'b1;
      end
      if (b_fire && b_cmd.emit) begin
        blk_valid <= 1'b1;
      end else if (blk_ready) begin
        blk_valid <= 1'b0;
      end
    end
  end

endmodule

>>> sv/block_average_mosaic_unit.sv
`timescale 1ns / 1ps
// Takes one grey pixel request per clock in raster order while the queue has
// room; a block mean reaches the output once the bottom-right pixel of its
// block has passed the queue, the command and result registers. The
// pace is set by the block column sum memory, which does one read-modify-write
// per pixel with the last write forwarded to the next read. A four-entry queue
// lets the input side keep running briefly while the output is held.
// ----------------------------------------------------------------------------
// Block average mosaic unit
// Accumulate per-block sums of a square frame and emit each block's mean.
// ----------------------------------------------------------------------------
module block_average_mosaic_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              pix_valid,
  output logic              pix_ready,
  input  bam_pkg::bam_in_t  pix_data,
  output logic              blk_valid,
  input  logic              blk_ready,
  output bam_pkg::bam_out_t blk_data
);

  import bam_pkg::*;

  logic               f_valid, f_ready, q_valid, q_ready;
  bam_cmd_t           f_cmd, q_cmd;
  logic [Q_CNT_W-1:0] q_level;

  bam_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix_data  (pix_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_cmd)
  );

  bam_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd),
    .level      (q_level)
  );

  bam_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd_data  (q_cmd),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk_data  (blk_data)
  );

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_ready) |-> (q_level != Q_CNT_W'(Q_DEPTH)))
    else $error("pixel request accepted into a full queue");

  assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |-> (q_level != '0))
    else $error("request taken from an empty queue");

  assert property (@(posedge clk) disable iff (rst)
    (blk_valid && blk_data.frame_done) |->
      (blk_data.block_row == COORD_FINAL) && (blk_data.block_col == COORD_FINAL))
    else $error("frame done flagged away from the last block");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block average mosaic unit testbench
// Streams grey pixel requests in raster order through the unit and checks
// every block mean against a cycle-free predictor of the per-column block
// sums. Short directed requests with repeated frame starts are followed by
// one band whose block columns are flat white, flat black or noisy, carried
// into its last pixel row. Both handshakes stall at random in two of three
// phases but not the last; the sender pauses for all results between phases.
// ----------------------------------------------------------------------------
module tb;
  import bam_pkg::*;

  typedef enum int {FILL_RANDOM, FILL_WHITE, FILL_BLACK} fill_t;

  localparam int QUIET_LIMIT    = 4000;
  localparam int TAIL_CYCLES    = 16;
  localparam int LAST_ROW_START = (BLOCK_SIZE - 1) * IMAGE_SIZE;
  localparam int PHASE_PIXELS   = 9 * BLOCK_SIZE;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     pix_valid = 1'b0;
  logic     pix_ready;
  bam_in_t  pix_data = '0;
  logic     blk_valid;
  logic     blk_ready = 1'b0;
  bam_out_t blk_data;

  bam_in_t     pending_pixels[$];
  bam_out_t    block_results[$];
  int unsigned column_sums[SUM_SLOTS];
  int unsigned next_row;
  int unsigned next_col;
  int          mean_drop;

  int send_idle_pct;
  int recv_idle_pct;
  bit pix_fire;
  bit blk_fire;
  int quiet_cycles;
  int pixels_taken;
  int means_checked;
  int frames_started;
  int mismatches;

  block_average_mosaic_unit dut (
    .clk      (clk),
    .rst      (rst),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix_data (pix_data),
    .blk_valid(blk_valid),
    .blk_ready(blk_ready),
    .blk_data (blk_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int floor_log2(int value);
    int n;
    n = 0;
    while (value > 1) begin
      value = value >> 1;
      n++;
    end
    return n;
  endfunction

  function automatic void predict_block_mean(bam_in_t req);
    int unsigned r, c, bc, br, ir, ic;
    bam_out_t    res;
    if (req.frame_start) begin
      next_row = 0;
      next_col = 0;
      frames_started++;
    end
    r = (next_row >= IMAGE_SIZE) ? 0 : next_row;
    c = (next_col >= IMAGE_SIZE) ? 0 : next_col;
    bc = c / BLOCK_SIZE;
    br = r / BLOCK_SIZE;
    ir = r % BLOCK_SIZE;
    ic = c % BLOCK_SIZE;
    if (bc < SUM_SLOTS) begin
      if (ir == 0 && ic == 0) begin
        column_sums[bc] = req.pixel;
      end else begin
        column_sums[bc] = column_sums[bc] + req.pixel;
      end
      if (ir == BLOCK_SIZE - 1 && ic == BLOCK_SIZE - 1 &&
          bc < FULL_BLOCKS && br < FULL_BLOCKS) begin
        res.block_mean = 8'(column_sums[bc] >> mean_drop);
        res.block_row  = 6'(br);
        res.block_col  = 6'(bc);
        res.frame_done = (br == FULL_BLOCKS - 1) && (bc == FULL_BLOCKS - 1);
        block_results.push_back(res);
      end
    end
    c++;
    if (c >= IMAGE_SIZE) begin
      c = 0;
      r++;
      if (r >= IMAGE_SIZE) begin
        r = 0;
      end
    end
    next_row = r;
    next_col = c;
  endfunction

  function automatic logic [7:0] fill_pixel(fill_t fill);
    case (fill)
      FILL_WHITE: return 8'hFF;
      FILL_BLACK: return 8'h00;
      default:    return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic fill_t column_fill(int col);
    case ((col / BLOCK_SIZE) % 4)
      0:       return FILL_WHITE;
      1:       return FILL_BLACK;
      default: return FILL_RANDOM;
    endcase
  endfunction

  task automatic queue_request(logic [7:0] pixel, logic frame_start);
    bam_in_t req;
    req.pixel       = pixel;
    req.frame_start = frame_start;
    pending_pixels.push_back(req);
  endtask

  task automatic queue_raster(int first, int count, bit restart);
    int col;
    for (int i = 0; i < count; i++) begin
      col = (first + i) % IMAGE_SIZE;
      queue_request(fill_pixel(column_fill(col)), restart && (i == 0));
    end
  endtask

  task automatic drain_requests();
    while (pending_pixels.size() != 0 || pix_valid) @(posedge clk);
    while (block_results.size() != 0) @(posedge clk);
  endtask

  // Monitor: check results, predict from accepted requests, watch for stalls.
  always @(posedge clk) begin
    bam_out_t exp_res;
    pix_fire = !rst && pix_valid && pix_ready;
    blk_fire = !rst && blk_valid && blk_ready;
    if (blk_fire) begin
      if (block_results.size() == 0) begin
        $display("%0t: unexpected block result, expected none, got %p", $time, blk_data);
        mismatches++;
      end else begin
        exp_res = block_results.pop_front();
        if (blk_data.block_mean !== exp_res.block_mean ||
            blk_data.block_row  !== exp_res.block_row  ||
            blk_data.block_col  !== exp_res.block_col  ||
            blk_data.frame_done !== exp_res.frame_done) begin
          $display("%0t: block result mismatch, expected %p, got %p",
                   $time, exp_res, blk_data);
          mismatches++;
        end
        means_checked++;
      end
    end
    if (pix_fire) begin
      predict_block_mean(pix_data);
      pixels_taken++;
    end
    if (rst || pix_fire || blk_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, block_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Driver: present requests and toggle the result ready.
  always @(negedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
      blk_ready <= 1'b0;
    end else begin
      blk_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (pix_valid && !pix_fire) begin
        // hold the current request
      end else if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        pix_data  <= pending_pixels.pop_front();
        pix_valid <= 1'b1;
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  initial begin
    mean_drop = 2 * floor_log2(BLOCK_SIZE);
    foreach (column_sums[i]) column_sums[i] = 0;
    next_row = 0;
    next_col = 0;
    send_idle_pct = 17;
    recv_idle_pct = 64;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    queue_request(8'h00, 1'b1);
    queue_request(8'hFF, 1'b0);
    queue_request(8'h00, 1'b0);
    queue_request(8'h55, 1'b0);
    queue_request(8'hAA, 1'b1);
    queue_request(8'hFF, 1'b1);
    queue_request(8'h00, 1'b1);
    queue_request(8'hFF, 1'b0);
    queue_request(8'h0F, 1'b0);
    queue_request(8'hF0, 1'b0);
    queue_raster(0, LAST_ROW_START + PHASE_PIXELS, 1'b1);
    drain_requests();

    send_idle_pct = 64;
    recv_idle_pct = 17;
    queue_raster(LAST_ROW_START + PHASE_PIXELS, PHASE_PIXELS, 1'b0);
    drain_requests();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_raster(LAST_ROW_START + 2 * PHASE_PIXELS, PHASE_PIXELS, 1'b0);
    drain_requests();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (block_results.size() != 0) begin
      $display("%0t: %0d block results never arrived, expected %p first",
               $time, block_results.size(), block_results[0]);
      mismatches++;
    end
    $display("Streamed %0d pixel requests with %0d frame starts, restarts and one band",
             pixels_taken, frames_started);
    $display("into its last pixel row; compared %0d block means, %0d mismatches.",
             means_checked, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/bam_pkg.sv
sv/bam_ram.sv
sv/bam_front.sv
sv/bam_queue.sv
sv/bam_back.sv
sv/block_average_mosaic_unit.sv
tb/tb.sv
